// File: hdl/scr_pkg.sv
// scr_pkg: shared types, constants and fixed-point helpers for the scatter rotate block
// no dependencies; used by every module under hdl
`default_nettype none

package scr_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  // floor square root of a value up to 2^30 takes one result bit per step
  localparam int ISQRT_STEPS   = 16;
  localparam int ROT_LAT       = CORDIC_STAGES + 2;
  localparam int VEC_LAT       = CORDIC_STAGES + 1;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [33:0] cw_t;
  typedef logic [31:0]        bam_t;
  typedef logic [ANGLE_BITS-1:0] ang_t;

  localparam cw_t  K_Q30         = 34'sd652032874;
  localparam bam_t QUARTER_TURN  = 32'h4000_0000;
  localparam bam_t HALF_TURN     = 32'h8000_0000;
  localparam bam_t THREE_QUARTER = 32'hC000_0000;

  typedef struct packed {
    ang_t theta_in;
    ang_t phi_in;
    ang_t scatter_theta;
    ang_t scatter_phi;
    logic collision;
  } in_beat_t;

  typedef struct packed {
    ang_t theta_out;
    ang_t phi_out;
  } out_beat_t;

  function automatic bam_t atan_tab(input int i);
    bam_t t;
    case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000003;
      29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // q2.30 to q1.15, round half up, saturate
  function automatic q15_t q30_to_q15(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd16384) >>> 15;
    if (t > 36'sd32767) begin
      return 16'sh7FFF;
    end
    if (t < -36'sd32768) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  function automatic q15_t mul15(input q15_t a, input q15_t b);
    logic signed [31:0] p;
    p = a * b;
    return q30_to_q15(36'(p));
  endfunction

  function automatic bam_t angle_in(input ang_t v);
    return bam_t'(v) << (32 - ANGLE_BITS);
  endfunction

  function automatic ang_t angle_out(input bam_t z);
    bam_t s;
    s = z + (32'd1 << (31 - ANGLE_BITS));
    return s[31 -: ANGLE_BITS];
  endfunction

endpackage

`default_nettype wire

// File: hdl/scr_cordic_rot.sv
// scr_cordic_rot: pipelined rotation-mode cordic, binary angle in, q1.15 sine and cosine out
// depends on scr_pkg; an input register, one register per iteration and an output register, all moving while en is high
`default_nettype none

module scr_cordic_rot (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire scr_pkg::bam_t angle,
  output scr_pkg::q15_t      sin_q,
  output scr_pkg::q15_t      cos_q
);

  scr_pkg::cw_t  x_r    [0:scr_pkg::CORDIC_STAGES];
  scr_pkg::cw_t  y_r    [0:scr_pkg::CORDIC_STAGES];
  scr_pkg::cw_t  z_r    [0:scr_pkg::CORDIC_STAGES];
  logic          flip_r [0:scr_pkg::CORDIC_STAGES];
  scr_pkg::q15_t sin_r, cos_r;
  scr_pkg::bam_t a_sum, a_adj;
  scr_pkg::cw_t  xf, yf;

  // fold the left half plane onto the right one
  always_comb begin
    a_sum = angle + scr_pkg::QUARTER_TURN;
    a_adj = a_sum[31] ? angle + scr_pkg::HALF_TURN : angle;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= scr_pkg::K_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= 34'(signed'(a_adj));
      flip_r[0] <= a_sum[31];
    end
  end

  for (genvar i = 0; i < scr_pkg::CORDIC_STAGES; i++) begin : g_iter
    localparam scr_pkg::cw_t ATN = $signed({2'b00, scr_pkg::atan_tab(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end
      end
    end
  end

  always_comb begin
    xf = flip_r[scr_pkg::CORDIC_STAGES] ? -x_r[scr_pkg::CORDIC_STAGES]
                                        : x_r[scr_pkg::CORDIC_STAGES];
    yf = flip_r[scr_pkg::CORDIC_STAGES] ? -y_r[scr_pkg::CORDIC_STAGES]
                                        : y_r[scr_pkg::CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= scr_pkg::q30_to_q15(36'(xf));
      sin_r <= scr_pkg::q30_to_q15(36'(yf));
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

`default_nettype wire

// File: hdl/scr_cordic_vec.sv
// scr_cordic_vec: pipelined vectoring-mode cordic giving atan2(y, x) as a 32-bit binary angle
// depends on scr_pkg; an input register and one register per iteration, all moving while en is high
`default_nettype none

module scr_cordic_vec (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic signed [16:0] y_q,
  input  wire scr_pkg::q15_t     x_q,
  output scr_pkg::bam_t          angle
);

  scr_pkg::cw_t  x_r [0:scr_pkg::CORDIC_STAGES];
  scr_pkg::cw_t  y_r [0:scr_pkg::CORDIC_STAGES];
  scr_pkg::bam_t z_r [0:scr_pkg::CORDIC_STAGES];
  scr_pkg::cw_t  x0, y0;

  // inputs scaled by 2^14
  always_comb begin
    x0 = $signed({{4{x_q[15]}}, x_q, 14'b0});
    y0 = $signed({{3{y_q[16]}}, y_q, 14'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (x0 < 0) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        z_r[0] <= scr_pkg::HALF_TURN;
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < scr_pkg::CORDIC_STAGES; i++) begin : g_iter
    localparam scr_pkg::bam_t ATN = scr_pkg::atan_tab(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign angle = z_r[scr_pkg::CORDIC_STAGES];

endmodule

`default_nettype wire

// File: hdl/scatter_direction_rotate_unit.sv
// scatter_direction_rotate_unit: top level, rotates a track direction by scatter angles
// depends on scr_pkg, scr_cordic_rot, scr_cordic_vec
//
//   channel | ports                          | beat
//   --------+--------------------------------+------------------------------------------
//   in      | in_valid, in_ready, in_data    | theta_in, phi_in, scatter angles, collision
//   out     | out_valid, out_ready, out_data | theta_out, phi_out
//   cfg     | cfg_valid, cfg_ready, cfg_data | scatter_enable
//
// one beat enters per cycle while the pipeline advances; the path to out_valid runs through
// the two cordic chains and the square root chain, one iteration per register stage
// the whole pipeline moves on one enable: it advances whenever the output register is
// empty or its beat is being taken, so a stall freezes every stage in place
// reset clears the valid bits and scatter_enable; data registers are not reset
`default_nettype none

module scatter_direction_rotate_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire scr_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output scr_pkg::out_beat_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  // register index of each section, counted from the accepting edge
  localparam int P1_IDX   = scr_pkg::ROT_LAT;
  localparam int LAST_IDX = scr_pkg::ROT_LAT + 4 + scr_pkg::ISQRT_STEPS + scr_pkg::VEC_LAT;

  typedef struct packed {
    logic          rot;
    scr_pkg::ang_t theta_in;
    scr_pkg::ang_t phi_in;
  } side_t;

  typedef struct packed {
    logic [31:0]   v;
    logic [31:0]   r;
    scr_pkg::q15_t c2;
  } isq_t;

  logic                scat_en_r;
  logic                adv;
  logic                vld_r  [0:LAST_IDX];
  side_t               side_r [0:LAST_IDX];

  // sines and cosines of the four angles
  scr_pkg::q15_t       st, ct, sp, cp, sst, cst, ssp, csp;

  // first product stage
  scr_pkg::q15_t       v0_r, v1_r, v2_r, m_cpct_r, m_stcp_r, m_ctsp_r, m_stsp_r;
  scr_pkg::q15_t       sp_r, cp_r, st_r, ct_r;
  // second product stage
  logic signed [31:0]  pr_r [0:7];
  // rotated unit vector
  scr_pkg::q15_t       c0_r, c1_r, c2_r;
  logic signed [35:0]  c0_sum, c1_sum, c2_sum;
  logic signed [31:0]  c2_sq;

  isq_t                isq_r [0:scr_pkg::ISQRT_STEPS];
  scr_pkg::bam_t       phi_ang, th_ang;
  scr_pkg::bam_t       ph_d_r [0:scr_pkg::ISQRT_STEPS];
  scr_pkg::bam_t       th_cl;
  scr_pkg::out_beat_t  out_r, out_nxt;

  // the pipeline moves when the output register is free or being drained
  assign adv       = !vld_r[LAST_IDX] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scat_en_r <= 1'b0;
    end else if (cfg_valid) begin
      scat_en_r <= cfg_data;
    end
  end

  // valid bits and pass-through data travel next to the arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST_IDX; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= LAST_IDX; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{rot: scat_en_r & in_data.collision,
                     theta_in: in_data.theta_in, phi_in: in_data.phi_in};
      for (int k = 1; k <= LAST_IDX; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // four sine/cosine pipelines side by side
  scr_cordic_rot u_rot_theta (
    .clk(clk), .en(adv), .angle(scr_pkg::angle_in(in_data.theta_in)),
    .sin_q(st), .cos_q(ct)
  );
  scr_cordic_rot u_rot_phi (
    .clk(clk), .en(adv), .angle(scr_pkg::angle_in(in_data.phi_in)),
    .sin_q(sp), .cos_q(cp)
  );
  scr_cordic_rot u_rot_stheta (
    .clk(clk), .en(adv), .angle(scr_pkg::angle_in(in_data.scatter_theta)),
    .sin_q(sst), .cos_q(cst)
  );
  scr_cordic_rot u_rot_sphi (
    .clk(clk), .en(adv), .angle(scr_pkg::angle_in(in_data.scatter_phi)),
    .sin_q(ssp), .cos_q(csp)
  );

  // scatter vector and rounded frame terms
  always_ff @(posedge clk) begin
    if (adv) begin
      v0_r     <= scr_pkg::mul15(sst, csp);
      v1_r     <= scr_pkg::mul15(sst, ssp);
      v2_r     <= cst;
      m_cpct_r <= scr_pkg::mul15(cp, ct);
      m_stcp_r <= scr_pkg::mul15(st, cp);
      m_ctsp_r <= scr_pkg::mul15(ct, sp);
      m_stsp_r <= scr_pkg::mul15(st, sp);
      sp_r     <= sp;
      cp_r     <= cp;
      st_r     <= st;
      ct_r     <= ct;
    end
  end

  // full-precision products of the frame matrix by the scatter vector
  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r[0] <= sp_r * v0_r;
      pr_r[1] <= m_cpct_r * v1_r;
      pr_r[2] <= m_stcp_r * v2_r;
      pr_r[3] <= cp_r * v0_r;
      pr_r[4] <= m_ctsp_r * v1_r;
      pr_r[5] <= m_stsp_r * v2_r;
      pr_r[6] <= st_r * v1_r;
      pr_r[7] <= ct_r * v2_r;
    end
  end

  // exact q2.30 sums, then one rounding each
  always_comb begin
    c0_sum = -36'(pr_r[0]) - 36'(pr_r[1]) + 36'(pr_r[2]);
    c1_sum =  36'(pr_r[3]) - 36'(pr_r[4]) + 36'(pr_r[5]);
    c2_sum =  36'(pr_r[6]) + 36'(pr_r[7]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r <= scr_pkg::q30_to_q15(c0_sum);
      c1_r <= scr_pkg::q30_to_q15(c1_sum);
      c2_r <= scr_pkg::q30_to_q15(c2_sum);
    end
  end

  // azimuth of the new direction
  scr_cordic_vec u_vec_phi (
    .clk(clk), .en(adv), .y_q(17'(c1_r)), .x_q(c0_r), .angle(phi_ang)
  );

  // sine of the new polar angle: floor sqrt(2^30 - c2^2), one root bit per stage
  assign c2_sq = c2_r * c2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      isq_r[0] <= '{v: 32'h4000_0000 - 32'(c2_sq), r: '0, c2: c2_r};
    end
  end

  for (genvar j = 0; j < scr_pkg::ISQRT_STEPS; j++) begin : g_isqrt
    localparam logic [31:0] BIT = 32'd1 << (2 * (scr_pkg::ISQRT_STEPS - 1 - j));
    always_ff @(posedge clk) begin
      if (adv) begin
        isq_r[j+1].c2 <= isq_r[j].c2;
        if (isq_r[j].v >= isq_r[j].r + BIT) begin
          isq_r[j+1].v <= isq_r[j].v - (isq_r[j].r + BIT);
          isq_r[j+1].r <= (isq_r[j].r >> 1) + BIT;
        end else begin
          isq_r[j+1].v <= isq_r[j].v;
          isq_r[j+1].r <= isq_r[j].r >> 1;
        end
      end
    end
  end

  scr_cordic_vec u_vec_theta (
    .clk(clk), .en(adv),
    .y_q($signed({1'b0, isq_r[scr_pkg::ISQRT_STEPS].r[15:0]})),
    .x_q(isq_r[scr_pkg::ISQRT_STEPS].c2), .angle(th_ang)
  );

  // hold the azimuth until the polar angle catches up
  always_ff @(posedge clk) begin
    if (adv) begin
      ph_d_r[0] <= phi_ang;
      for (int k = 1; k <= scr_pkg::ISQRT_STEPS; k++) begin
        ph_d_r[k] <= ph_d_r[k-1];
      end
    end
  end

  // polar overshoot clamps to the half turn, undershoot (wrapped) to zero
  always_comb begin
    th_cl = th_ang;
    if (th_ang > scr_pkg::HALF_TURN) begin
      th_cl = (th_ang >= scr_pkg::THREE_QUARTER) ? '0 : scr_pkg::HALF_TURN;
    end
    if (side_r[LAST_IDX-1].rot) begin
      out_nxt.theta_out = scr_pkg::angle_out(th_cl);
      out_nxt.phi_out   = scr_pkg::angle_out(ph_d_r[scr_pkg::ISQRT_STEPS]);
    end else begin
      // no scatter: direction passes as given
      out_nxt.theta_out = side_r[LAST_IDX-1].theta_in;
      out_nxt.phi_out   = side_r[LAST_IDX-1].phi_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[LAST_IDX];
  assign out_data  = out_r;

  // pass-through copy at the output stage is not needed beyond this point
  logic unused_side;
  assign unused_side = side_r[LAST_IDX].rot ^ (^side_r[LAST_IDX].theta_in)
                       ^ (^side_r[LAST_IDX].phi_in) ^ (^isq_r[scr_pkg::ISQRT_STEPS].v)
                       ^ (^isq_r[scr_pkg::ISQRT_STEPS].r[31:16]) ^ vld_r[P1_IDX];

endmodule

`default_nettype wire

// File: hdl/scr_checker.sv
// scr_checker: port-level assertions for scatter_direction_rotate_unit, bound to the top level
// depends on scr_pkg and scatter_direction_rotate_unit
`default_nettype none

module scr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire scr_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // input is taken exactly when the output stage can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready out of step with output stage");

  // a new result only shows after the pipeline advanced
  a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result appeared without pipeline advance");

endmodule

bind scatter_direction_rotate_unit scr_checker u_scr_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

`default_nettype wire

// File: verif/scatter_direction_rotate_unit_tb.sv
// scatter_direction_rotate_unit_tb: self-checking bench for the scatter rotate block
// depends on scr_pkg and scatter_direction_rotate_unit; predicts every beat in-bench
`default_nettype none

module scatter_direction_rotate_unit_tb;

  localparam int PIPE_DEPTH = 2 * scr_pkg::CORDIC_STAGES + scr_pkg::ISQRT_STEPS + 8;
  localparam int N_RANDOM   = 1500;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  scr_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  scr_pkg::out_beat_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  scatter_direction_rotate_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // bench-side copy of the enable register
  logic               enable_model = 1'b0;
  scr_pkg::in_beat_t  pending_beats[$];
  scr_pkg::out_beat_t expected_dirs[$];
  int        n_errors = 0;
  bit        no_idle = 1'b0;     // last part of the run: no gaps on either side
  bit        hold_sink = 1'b0;   // long receiver hold-off
  bit        hold_source = 1'b0; // sender pause until drained
  bit        in_taken = 1'b0;    // input beat accepted at the last rising edge
  int        src_gap = 0;
  int        sink_gap = 0;

  // ---------------------------------------------------------------- predictor math
  function automatic longint rnd_q15(longint v);
    longint t;
    t = (v + 16384) >>> 15;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return rnd_q15(a * b);
  endfunction

  // rotation-mode cordic: sine and cosine of a 32-bit binary angle, q1.15
  task automatic sin_cos(input bit [31:0] ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit mirror;
    x = 652032874;
    y = 0;
    mirror = 1'b0;
    if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      ang = ang + 32'h8000_0000;
      mirror = 1'b1;
    end
    z = (ang >= 32'h8000_0000) ? longint'(ang) - 64'sd4294967296 : longint'(ang);
    for (int i = 0; i < scr_pkg::CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(scr_pkg::atan_tab(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(scr_pkg::atan_tab(i));
      end
      x = nx;
    end
    if (mirror) begin
      x = -x;
      y = -y;
    end
    c = rnd_q15(x);
    s = rnd_q15(y);
  endtask

  // vectoring-mode cordic: angle of (x, y) as a 32-bit binary angle
  function automatic bit [31:0] vec_angle(longint yq, longint xq);
    longint x, y, nx;
    bit [31:0] z;
    x = xq * 16384;
    y = yq * 16384;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < scr_pkg::CORDIC_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += scr_pkg::atan_tab(i);
        x = nx;
      end else if (y < 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= scr_pkg::atan_tab(i);
        x = nx;
      end
    end
    return z;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit [15:0] to_ang16(bit [31:0] z);
    bit [31:0] s;
    s = z + 32'h0000_8000;
    return s[31:16];
  endfunction

  task automatic predict_direction(input scr_pkg::in_beat_t b, output scr_pkg::out_beat_t r);
    longint st, ct, sp, cp, sst, cst, ssp, csp, v0, v1, v2, d0, d1, d2, rad;
    bit [31:0] pol, azi;
    if (!enable_model || !b.collision) begin
      r.theta_out = b.theta_in;
      r.phi_out   = b.phi_in;
      return;
    end
    sin_cos({b.theta_in, 16'h0}, st, ct);
    sin_cos({b.phi_in, 16'h0}, sp, cp);
    sin_cos({b.scatter_theta, 16'h0}, sst, cst);
    sin_cos({b.scatter_phi, 16'h0}, ssp, csp);
    v0 = fx_mul(sst, csp);
    v1 = fx_mul(sst, ssp);
    v2 = cst;
    d0 = rnd_q15(-sp * v0 - fx_mul(cp, ct) * v1 + fx_mul(st, cp) * v2);
    d1 = rnd_q15(cp * v0 - fx_mul(ct, sp) * v1 + fx_mul(st, sp) * v2);
    d2 = rnd_q15(st * v1 + ct * v2);
    azi = vec_angle(d1, d0);
    rad = floor_sqrt(64'sd1073741824 - d2 * d2);
    pol = vec_angle(rad, d2);
    // polar overshoot clamps to the nearer end of [0, half turn]
    if (pol > 32'h8000_0000) pol = (pol >= 32'hC000_0000) ? 32'h0 : 32'h8000_0000;
    r.theta_out = to_ang16(pol);
    r.phi_out   = to_ang16(azi);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------- input capture
  // a beat is taken at the rising edge where valid and ready are both high;
  // predict with the enable in force then
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      scr_pkg::out_beat_t r;
      predict_direction(in_data, r);
      expected_dirs.push_back(r);
    end
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!hold_source && pending_beats.size() > 0) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // receiver
      if (hold_sink) begin
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 6);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_dirs.size() == 0) begin
        report_mismatch("unexpected beat", out_data.theta_out, -1);
      end else begin
        scr_pkg::out_beat_t e;
        e = expected_dirs.pop_front();
        if (out_data.theta_out !== e.theta_out)
          report_mismatch("theta_out", out_data.theta_out, e.theta_out);
        if (out_data.phi_out !== e.phi_out)
          report_mismatch("phi_out", out_data.phi_out, e.phi_out);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  function automatic scr_pkg::in_beat_t rand_beat();
    scr_pkg::in_beat_t b;
    b.theta_in      = (($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 32768)));
    b.phi_in        = 16'($urandom);
    b.scatter_theta = (($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 32768)));
    b.scatter_phi   = 16'($urandom);
    b.collision     = ($urandom_range(0, 3) != 0);
    return b;
  endfunction

  function automatic scr_pkg::in_beat_t mk(int t, int p, int st, int sp, bit c);
    scr_pkg::in_beat_t b;
    b.theta_in = 16'(t);
    b.phi_in = 16'(p);
    b.scatter_theta = 16'(st);
    b.scatter_phi = 16'(sp);
    b.collision = c;
    return b;
  endfunction

  // wait until every queued beat is accepted and its result has arrived
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_dirs.size() > 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    enable_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_set();
    pending_beats.push_back(mk(0, 0, 0, 0, 1));
    pending_beats.push_back(mk(32768, 65535, 32768, 65535, 1));
    pending_beats.push_back(mk(16384, 16384, 16384, 0, 1));
    pending_beats.push_back(mk(0, 12345, 0, 0, 1));          // zero azimuth vector
    pending_beats.push_back(mk(32768, 0, 0, 0, 1));
    pending_beats.push_back(mk(1, 65535, 1, 1, 1));          // azimuth near wrap
    pending_beats.push_back(mk(16384, 0, 32768, 32768, 1));  // scatter theta at a half turn
    pending_beats.push_back(mk(65535, 40000, 65535, 1, 1));  // polar out of range
    pending_beats.push_back(mk(49152, 8192, 40000, 3000, 1));
    pending_beats.push_back(mk(12000, 30000, 5000, 60000, 0)); // no collision
    pending_beats.push_back(mk(21845, 43690, 10923, 54613, 1));
    pending_beats.push_back(mk(32767, 32768, 1, 65535, 1));
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_set();                 // enable still at reset value: pass-through
    drain();
    write_enable(1'b1);
    directed_set();
    drain();

    // long receiver hold-off while the sender keeps offering beats
    hold_sink = 1'b1;
    repeat (200) pending_beats.push_back(rand_beat());
    for (int i = 0; i < 150; i++) @(posedge clk);
    hold_sink = 1'b0;
    drain();

    // random traffic in phases across both settings of the enable
    for (int ph = 0; ph < 4; ph++) begin
      write_enable(ph != 2);
      repeat (N_RANDOM / 5) pending_beats.push_back(rand_beat());
      if (ph == 1) begin
        // sender pause until every result is in
        while (pending_beats.size() > 100) @(posedge clk);
        hold_source = 1'b1;
        while (in_valid || expected_dirs.size() > 0) @(posedge clk);
        hold_source = 1'b0;
      end
      drain();
    end

    // last part: full rate, no idling
    no_idle = 1'b1;
    write_enable(1'b1);
    repeat (N_RANDOM / 5) pending_beats.push_back(rand_beat());
    drain();

    if (n_errors == 0) begin
      $display("scatter_direction_rotate_unit_tb passed");
    end else begin
      $display("scatter_direction_rotate_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("scatter_direction_rotate_unit_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
